// ----- rtl/free_block_bitmap_allocator_defines.svh -----
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBBA_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fbba_pkg.sv -----
`timescale 1ns / 1ps

package fbba_pkg;

    localparam int IDX_W       = 12;
    localparam int CFG_W       = 13;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int INDEX_LIMIT = 4096;

    localparam logic [CFG_W-1:0] RESERVED_RESET = 13'd12;

    // Register select: paddr bit above the byte offset
    localparam logic REG_RESERVED = 1'b0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_MARK_USED = 2'd2,
        OP_FORMAT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] reserved_blocks;
    } cfg_t;

endpackage

// ----- rtl/fbba_intf.sv -----
`timescale 1ns / 1ps

interface fbba_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [fbba_pkg::IDX_W-1:0] block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface fbba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [fbba_pkg::IDX_W-1:0] block_number;
    logic                       status;
    logic                       prior_free;

    modport source (output valid, output block_number, output status, output prior_free,
                    input ready);
    modport sink   (input valid, input block_number, input status, input prior_free,
                    output ready);
endinterface

// ----- rtl/free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
`include "free_block_bitmap_allocator_defines.svh"

// First-fit block allocator over a free map (1 = free) held in one single-port-write,
// one-read synchronous RAM of MAP_WORD_BITS-bit words. A hint register points at the
// lowest map word that may still hold a free block, so allocate reads from there one
// word per cycle. Release and mark-used split the index by a reciprocal multiply,
// read the RAM word, then modify it and write it back. Format rewrites every word,
// one per cycle. After reset the same pass runs once (over MAP_WORDS words, 128 by
// default) before the first request is accepted; configuration writes are taken
// meanwhile and apply at the next format.
// A result waits in the output register until taken, and the next request may be
// accepted meanwhile; a request finishes only once that register is free.
module free_block_bitmap_allocator #(
    parameter int BLOCK_COUNT   = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fbba_req_if.sink                      req,
    fbba_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbba_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbba_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int W          = MAP_WORD_BITS;
    localparam int MAP_WORDS  = (BLOCK_COUNT + W - 1) / W;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW         = $clog2(W);
    localparam int CW0        = $clog2(BLOCK_COUNT + W + 1);
    localparam int CW         = (CW0 > fbba_pkg::CFG_W) ? CW0 : fbba_pkg::CFG_W;
    localparam int LIMIT      = (BLOCK_COUNT < fbba_pkg::INDEX_LIMIT) ? BLOCK_COUNT
                                                                      : fbba_pkg::INDEX_LIMIT;
    localparam int SCAN_WORDS = (LIMIT + W - 1) / W;
    localparam int HW         = $clog2(SCAN_WORDS + 1);
    localparam int RECIP      = fbba_pkg::INDEX_LIMIT / W;
    localparam int IW         = fbba_pkg::IDX_W;

    localparam logic [CW-1:0] NUM_C          = CW'(BLOCK_COUNT);
    localparam logic [CW-1:0] LIMIT_C        = CW'(LIMIT);
    localparam logic [CW-1:0] W_C            = CW'(W);
    localparam logic [AW-1:0] LAST_ADDR      = AW'(MAP_WORDS - 1);
    localparam logic [AW-1:0] SCAN_LAST_ADDR = AW'(SCAN_WORDS - 1);
    localparam logic [HW-1:0] SCAN_WORDS_H   = HW'(SCAN_WORDS);

    // Count of word bits whose block lies below hi, for a word starting at base
    function automatic logic [BW:0] span(input logic [CW-1:0] hi, input logic [CW-1:0] base);
        logic [CW-1:0] d;
        d = hi - base;
        if (hi <= base)
        begin
            span = '0;
        end
        else if (d >= W_C)
        begin
            span = (BW+1)'(W);
        end
        else
        begin
            span = d[BW:0];
        end
    endfunction

    function automatic logic [W-1:0] below(input logic [BW:0] cnt);
        logic [W-1:0] m;
        for (int b = 0; b < W; b++)
        begin
            m[b] = ((BW+1)'(b) < cnt);
        end
        below = m;
    endfunction

    fbba_pkg::cfg_t cfg;

    fbba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbba_pkg::state_t state_reg, state_next;
    fbba_pkg::op_t    op_reg, op_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    q_reg, q_next;
    logic [AW-1:0]    word_addr_reg, word_addr_next;
    logic [CW-1:0]    word_base_reg, word_base_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic [HW-1:0]    hint_reg, hint_next;
    logic [CW-1:0]    hint_base_reg, hint_base_next;
    logic             sweep_format_reg, sweep_format_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [IW-1:0]    num_reg, num_next;
    logic             status_reg, status_next;
    logic             pf_reg, pf_next;

    logic [W-1:0]     map_mem [MAP_WORDS];
    logic [W-1:0]     rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [W-1:0]     wr_data;

    logic             accept;
    logic             slot_free;
    logic             rsp_load;
    logic             idx_out_of_map;
    logic             hint_empty;
    logic [CW-1:0]    sweep_reserved;
    logic [W-1:0]     sweep_pattern;
    logic [W-1:0]     sweep_scan_mask;
    logic [W-1:0]     eval_mask;
    logic [W-1:0]     eval_free;
    logic [W-1:0]     low_bit;
    logic [BW-1:0]    low_idx;
    logic [IW-1:0]    qw;
    logic [IW-1:0]    rem;
    logic [IW-1:0]    rem_fix;
    logic [IW-1:0]    q_fix;
    logic [W-1:0]     bit_onehot;

    assign req.ready = (state_reg == fbba_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign idx_out_of_map = (CW'(req.block_index) >= NUM_C);
    assign hint_empty     = (hint_reg == SCAN_WORDS_H);

    // Format uses the configured count; the pass after reset uses the reset value
    assign sweep_reserved  = sweep_format_reg ? CW'(cfg.reserved_blocks)
                                              : CW'(fbba_pkg::RESERVED_RESET);
    assign sweep_pattern   = below(span(NUM_C, word_base_reg))
                           & ~below(span(sweep_reserved, word_base_reg));
    assign sweep_scan_mask = below(span(LIMIT_C, word_base_reg));

    assign eval_mask = below(span(LIMIT_C, word_base_reg));
    assign eval_free = rd_data_reg & eval_mask;
    assign low_bit   = eval_free & (~eval_free + W'(1));

    always_comb
    begin
        low_idx = '0;
        for (int b = 0; b < W; b++)
        begin
            low_idx = low_idx | (low_bit[b] ? BW'(b) : '0);
        end
    end

    // Index split: quotient estimate is exact or one low, fix with one compare
    assign qw      = IW'(q_reg * W);
    assign rem     = idx_reg - qw;
    assign q_fix   = (rem >= IW'(W)) ? (q_reg + IW'(1)) : q_reg;
    assign rem_fix = (rem >= IW'(W)) ? (rem - IW'(W)) : rem;

    assign bit_onehot = W'(1) << bit_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbba_pkg::ST_SWEEP:
            begin
                if (word_addr_reg == LAST_ADDR)
                begin
                    state_next = sweep_format_reg ? fbba_pkg::ST_DONE : fbba_pkg::ST_IDLE;
                end
            end
            fbba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (fbba_pkg::op_t'(req.opcode))
                        fbba_pkg::OP_ALLOC:
                            state_next = hint_empty ? fbba_pkg::ST_DONE : fbba_pkg::ST_EVAL;
                        fbba_pkg::OP_FORMAT:
                            state_next = fbba_pkg::ST_SWEEP;
                        default:
                            state_next = idx_out_of_map ? fbba_pkg::ST_DONE : fbba_pkg::ST_DIV;
                    endcase
                end
            end
            fbba_pkg::ST_DIV:
                state_next = fbba_pkg::ST_READ;
            fbba_pkg::ST_READ:
                state_next = fbba_pkg::ST_EVAL;
            fbba_pkg::ST_EVAL:
            begin
                if (op_reg == fbba_pkg::OP_ALLOC && eval_free == '0
                    && word_addr_reg != SCAN_LAST_ADDR)
                begin
                    state_next = fbba_pkg::ST_EVAL;
                end
                else if (slot_free)
                begin
                    state_next = fbba_pkg::ST_IDLE;
                end
            end
            fbba_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = fbba_pkg::ST_IDLE;
                end
            end
            default:
                state_next = fbba_pkg::ST_IDLE;
        endcase
    end

    // Datapath, map access and result
    always_comb
    begin
        op_next           = op_reg;
        idx_next          = idx_reg;
        q_next            = q_reg;
        word_addr_next    = word_addr_reg;
        word_base_next    = word_base_reg;
        bit_next          = bit_reg;
        hint_next         = hint_reg;
        hint_base_next    = hint_base_reg;
        sweep_format_next = sweep_format_reg;
        rd_en             = 1'b0;
        rd_addr           = word_addr_reg;
        wr_en             = 1'b0;
        wr_addr           = word_addr_reg;
        wr_data           = rd_data_reg;
        rsp_load          = 1'b0;
        num_next          = num_reg;
        status_next       = status_reg;
        pf_next           = pf_reg;

        unique case (state_reg)
            fbba_pkg::ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_data = sweep_pattern;
                // Advance the hint past words with nothing allocatable
                if (!hint_empty && CW'(hint_reg) == CW'(word_addr_reg)
                    && (sweep_pattern & sweep_scan_mask) == '0)
                begin
                    hint_next      = hint_reg + HW'(1);
                    hint_base_next = hint_base_reg + W_C;
                end
                word_addr_next = word_addr_reg + AW'(1);
                word_base_next = word_base_reg + W_C;
            end
            fbba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = fbba_pkg::op_t'(req.opcode);
                    idx_next = req.block_index;
                    case (fbba_pkg::op_t'(req.opcode))
                        fbba_pkg::OP_ALLOC:
                        begin
                            rd_en          = !hint_empty;
                            rd_addr        = AW'(hint_reg);
                            word_addr_next = AW'(hint_reg);
                            word_base_next = hint_base_reg;
                        end
                        fbba_pkg::OP_FORMAT:
                        begin
                            word_addr_next    = '0;
                            word_base_next    = '0;
                            hint_next         = '0;
                            hint_base_next    = '0;
                            sweep_format_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fbba_pkg::ST_DIV:
            begin
                q_next = IW'((idx_reg * RECIP) >> IW);
            end
            fbba_pkg::ST_READ:
            begin
                rd_en          = 1'b1;
                rd_addr        = AW'(q_fix);
                word_addr_next = AW'(q_fix);
                word_base_next = CW'(idx_reg - rem_fix);
                bit_next       = rem_fix[BW-1:0];
            end
            fbba_pkg::ST_EVAL:
            begin
                if (op_reg == fbba_pkg::OP_ALLOC)
                begin
                    if (eval_free != '0)
                    begin
                        if (slot_free)
                        begin
                            wr_en          = 1'b1;
                            wr_data        = rd_data_reg & ~low_bit;
                            hint_next      = HW'(word_addr_reg);
                            hint_base_next = word_base_reg;
                            rsp_load       = 1'b1;
                            num_next       = IW'(word_base_reg + CW'(low_idx));
                            status_next    = fbba_pkg::STATUS_OK;
                            pf_next        = 1'b0;
                        end
                    end
                    else if (word_addr_reg == SCAN_LAST_ADDR)
                    begin
                        if (slot_free)
                        begin
                            hint_next   = SCAN_WORDS_H;
                            rsp_load    = 1'b1;
                            num_next    = '0;
                            status_next = fbba_pkg::STATUS_NO_FREE;
                            pf_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = word_addr_reg + AW'(1);
                        word_addr_next = word_addr_reg + AW'(1);
                        word_base_next = word_base_reg + W_C;
                    end
                end
                else if (slot_free)
                begin
                    wr_en       = 1'b1;
                    wr_data     = (op_reg == fbba_pkg::OP_RELEASE) ? (rd_data_reg | bit_onehot)
                                                                   : (rd_data_reg & ~bit_onehot);
                    rsp_load    = 1'b1;
                    num_next    = idx_reg;
                    status_next = fbba_pkg::STATUS_OK;
                    pf_next     = rd_data_reg[bit_reg];
                    if (op_reg == fbba_pkg::OP_RELEASE && CW'(word_addr_reg) < CW'(hint_reg))
                    begin
                        hint_next      = HW'(word_addr_reg);
                        hint_base_next = word_base_reg;
                    end
                end
            end
            fbba_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_load          = 1'b1;
                    sweep_format_next = 1'b0;
                    num_next          = (op_reg == fbba_pkg::OP_ALLOC) ? '0 : idx_reg;
                    status_next       = (op_reg == fbba_pkg::OP_ALLOC) ? fbba_pkg::STATUS_NO_FREE
                                                                       : fbba_pkg::STATUS_OK;
                    pf_next           = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fbba_pkg::ST_SWEEP;
            op_reg           <= fbba_pkg::OP_ALLOC;
            word_addr_reg    <= '0;
            word_base_reg    <= '0;
            hint_reg         <= '0;
            hint_base_reg    <= '0;
            sweep_format_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            word_addr_reg    <= word_addr_next;
            word_base_reg    <= word_base_next;
            hint_reg         <= hint_next;
            hint_base_reg    <= hint_base_next;
            sweep_format_reg <= sweep_format_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        q_reg      <= q_next;
        bit_reg    <= bit_next;
        num_reg    <= num_next;
        status_reg <= status_next;
        pf_reg     <= pf_next;
    end

    // Free map RAM; a word written back is read again only by a later request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.block_number = num_reg;
    assign rsp.status       = status_reg;
    assign rsp.prior_free   = pf_reg;

    `FBBA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, req.valid && req.ready,
                      state_reg != fbba_pkg::ST_IDLE, "accepted request did not start")
    `FBBA_ASSERT(a_hint_in_range, clk, rst_n, 1'b1, hint_reg <= SCAN_WORDS_H,
                 "hint beyond scanned words")
    `FBBA_ASSERT(a_single_map_access, clk, rst_n, wr_en, !rd_en,
                 "map read and written in one cycle")
    `FBBA_ASSERT(a_scan_in_range, clk, rst_n,
                 state_reg == fbba_pkg::ST_EVAL && op_reg == fbba_pkg::OP_ALLOC,
                 word_addr_reg <= SCAN_LAST_ADDR, "allocate scan past last word")

endmodule

// ----- rtl/fbba_cfg.sv -----
`timescale 1ns / 1ps

module fbba_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbba_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbba_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fbba_pkg::cfg_t                cfg
);

    logic [fbba_pkg::CFG_W-1:0] reserved_reg;
    logic [fbba_pkg::CFG_W-1:0] reserved_next;
    logic                       sel;
    logic                       wr;

    assign pready = 1'b1;
    assign sel    = (paddr[fbba_pkg::PADDR_W-1] == fbba_pkg::REG_RESERVED);
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        reserved_next = reserved_reg;
        if (wr && sel)
        begin
            reserved_next = pwdata[fbba_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= fbba_pkg::RESERVED_RESET;
        end
        else
        begin
            reserved_reg <= reserved_next;
        end
    end

    assign prdata = sel ? fbba_pkg::PDATA_W'(reserved_reg) : '0;
    assign cfg.reserved_blocks = reserved_reg;

endmodule

// ----- test/tb_free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps

module tb_free_block_bitmap_allocator;

    localparam int BLOCK_COUNT = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic [fbba_pkg::IDX_W-1:0] block_number;
        logic                       status;
        logic                       prior_free;
    } result_t;

    typedef struct {
        bit                         do_cfg;
        logic [fbba_pkg::CFG_W-1:0] cfg_value;
        fbba_pkg::op_t              op;
        logic [fbba_pkg::IDX_W-1:0] index;
        bit                         typed;
        result_t                    result;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [fbba_pkg::PADDR_W-1:0] paddr;
    logic [fbba_pkg::PDATA_W-1:0] pwdata;
    logic [fbba_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    fbba_req_if req_if ();
    fbba_rsp_if rsp_if ();

    free_block_bitmap_allocator #(
        .BLOCK_COUNT   (BLOCK_COUNT),
        .MAP_WORD_BITS (32)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the free map (1 = free) and the reserved count
    bit   [BLOCK_COUNT-1:0]     shadow_free;
    logic [fbba_pkg::CFG_W-1:0] shadow_reserved;
    result_t                    predicted_results [$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    bit                         calm = 1'b0;

    // Directed rows; typed results only where they follow at a glance
    stim_row_t directed_rows [25] = '{
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd12, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd4095, 1'b1, '{12'd13, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_RELEASE, 12'd12, 1'b1, '{12'd12, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_RELEASE, 12'd12, 1'b1, '{12'd12, fbba_pkg::STATUS_OK, 1'b1}},
        '{1'b0, 13'd0, fbba_pkg::OP_MARK_USED, 12'd4095, 1'b1,
          '{12'd4095, fbba_pkg::STATUS_OK, 1'b1}},
        '{1'b0, 13'd0, fbba_pkg::OP_MARK_USED, 12'd4095, 1'b1,
          '{12'd4095, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_RELEASE, 12'd0, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'h555, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd12, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_RELEASE, 12'hAAA, 1'b0, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_MARK_USED, 12'h555, 1'b0,
          '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_FORMAT, 12'hFFF, 1'b1, '{12'hFFF, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd12, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b1, 13'd4096, fbba_pkg::OP_FORMAT, 12'd0, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1,
          '{12'd0, fbba_pkg::STATUS_NO_FREE, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_RELEASE, 12'd4095, 1'b1,
          '{12'd4095, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd4095, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1,
          '{12'd0, fbba_pkg::STATUS_NO_FREE, 1'b0}},
        '{1'b1, 13'd8191, fbba_pkg::OP_FORMAT, 12'h800, 1'b1,
          '{12'h800, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'hFFF, 1'b1,
          '{12'd0, fbba_pkg::STATUS_NO_FREE, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_MARK_USED, 12'd0, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b1, 13'd0, fbba_pkg::OP_FORMAT, 12'd0, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd0, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_ALLOC, 12'd0, 1'b1, '{12'd1, fbba_pkg::STATUS_OK, 1'b0}},
        '{1'b0, 13'd0, fbba_pkg::OP_MARK_USED, 12'd4095, 1'b1,
          '{12'd4095, fbba_pkg::STATUS_OK, 1'b1}}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void format_shadow();
        for (int i = 0; i < BLOCK_COUNT; i++)
        begin
            shadow_free[i] = (i >= shadow_reserved);
        end
    endfunction

    // Apply one request to the shadow map and return the result it yields
    function automatic result_t apply_request(input fbba_pkg::op_t op,
                                              input logic [fbba_pkg::IDX_W-1:0] idx);
        result_t res;
        res = '{block_number: idx, status: fbba_pkg::STATUS_OK, prior_free: 1'b0};
        case (op)
            fbba_pkg::OP_ALLOC:
            begin
                res.block_number = '0;
                res.status       = fbba_pkg::STATUS_NO_FREE;
                for (int i = 0; i < BLOCK_COUNT; i++)
                begin
                    if (shadow_free[i])
                    begin
                        shadow_free[i]   = 1'b0;
                        res.block_number = i[fbba_pkg::IDX_W-1:0];
                        res.status       = fbba_pkg::STATUS_OK;
                        break;
                    end
                end
            end
            fbba_pkg::OP_RELEASE, fbba_pkg::OP_MARK_USED:
            begin
                res.prior_free   = shadow_free[idx];
                shadow_free[idx] = (op == fbba_pkg::OP_RELEASE);
            end
            default:
            begin
                format_shadow();
            end
        endcase
        return res;
    endfunction

    task automatic send_request(input fbba_pkg::op_t op, input logic [fbba_pkg::IDX_W-1:0] idx,
                                input bit typed, input result_t typed_result);
        result_t pred;
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.block_index <= idx;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        pred = apply_request(op, idx);
        predicted_results.push_back(typed ? typed_result : pred);
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (predicted_results.size() != 0);
    endtask

    task automatic apb_transfer(input logic wr, input logic [fbba_pkg::PDATA_W-1:0] data,
                                output logic [fbba_pkg::PDATA_W-1:0] rd_data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {fbba_pkg::REG_RESERVED, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rd_data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reserved(input logic [fbba_pkg::CFG_W-1:0] value);
        logic [fbba_pkg::PDATA_W-1:0] rd_data;
        apb_transfer(1'b1, fbba_pkg::PDATA_W'(value), rd_data);
        shadow_reserved = value;
        apb_transfer(1'b0, '0, rd_data);
        if (rd_data !== fbba_pkg::PDATA_W'(value))
        begin
            $error("reserved_blocks readback: expected %0d, actual %0d", value, rd_data);
            error_count++;
        end
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp_res;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result transfer: block_number %0d", rsp_if.block_number);
                error_count++;
            end
            else
            begin
                exp_res = predicted_results.pop_front();
                if (rsp_if.block_number !== exp_res.block_number)
                begin
                    $error("block_number: expected %0d, actual %0d",
                           exp_res.block_number, rsp_if.block_number);
                    error_count++;
                end
                if (rsp_if.status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.prior_free !== exp_res.prior_free)
                begin
                    $error("prior_free: expected %0d, actual %0d",
                           exp_res.prior_free, rsp_if.prior_free);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_free_block_bitmap_allocator failed");
            $finish;
        end
    end

    initial
    begin
        fbba_pkg::op_t              op;
        logic [fbba_pkg::IDX_W-1:0] idx;
        logic [fbba_pkg::CFG_W-1:0] res_value;
        int                         pick;
        int                         base;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.opcode      = fbba_pkg::OP_ALLOC;
        req_if.block_index = '0;
        shadow_reserved    = fbba_pkg::RESERVED_RESET;
        format_shadow();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].do_cfg)
            begin
                wait_drained();
                set_reserved(directed_rows[r].cfg_value);
            end
            send_request(directed_rows[r].op, directed_rows[r].index,
                         directed_rows[r].typed, directed_rows[r].result);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            calm = (phase == 5);
            case (phase % 4)
                0: res_value = fbba_pkg::CFG_W'($urandom_range(0, 64));
                1: res_value = fbba_pkg::CFG_W'($urandom_range(4000, 4096));
                2: res_value = fbba_pkg::CFG_W'($urandom_range(4097, 8191));
                default: res_value = fbba_pkg::CFG_W'($urandom_range(0, 4096));
            endcase
            set_reserved(res_value);
            send_request(fbba_pkg::OP_FORMAT, fbba_pkg::IDX_W'($urandom_range(0, 4095)),
                         1'b0, '0);
            base = (res_value > 4032) ? 4032 : int'(res_value);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == PHASE_ITEMS / 2)
                begin
                    wait_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = fbba_pkg::OP_ALLOC;
                else if (pick < 72)
                    op = fbba_pkg::OP_RELEASE;
                else if (pick < 97)
                    op = fbba_pkg::OP_MARK_USED;
                else
                    op = fbba_pkg::OP_FORMAT;
                // Aim nearly half the indexes at the region where allocation happens
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    idx = fbba_pkg::IDX_W'(base + $urandom_range(0, 63));
                else if (pick < 70)
                    idx = fbba_pkg::IDX_W'($urandom_range(0, 127));
                else
                    idx = fbba_pkg::IDX_W'($urandom_range(0, 4095));
                send_request(op, idx, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && predicted_results.size() == 0)
        begin
            $display("tb_free_block_bitmap_allocator passed");
        end
        else
        begin
            $display("tb_free_block_bitmap_allocator failed");
        end
        $finish;
    end

endmodule
